// ----- design/fisa_pkg.sv -----
// Package for the free index stack allocator.
// Holds field widths, the action and command codes, the controller states and
// the status bundle shared by the controller and the datapath. No dependencies.
package fisa_pkg;

   localparam int IDX_W  = 6;   // slot index width
   localparam int CNT_W  = 7;   // free count and capacity width
   localparam int ACT_W  = 2;   // action code width
   localparam int REQ_W  = 8;   // req_tdata width
   localparam int RSP_W  = 16;  // rsp_tdata width
   localparam int CSR_AW = 3;   // csr_paddr width
   localparam int CSR_DW = 32;  // csr data width

   localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

   // Register word indexes (byte address divided by four).
   localparam logic [CSR_AW-3:0] REG_SLOT_CAPACITY = 1'b0;

   typedef enum logic [ACT_W-1:0] {
      ACT_ALLOC  = 2'd0,
      ACT_FREE   = 2'd1,
      ACT_REFILL = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   // Commands from the controller to the datapath.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_POP,             // decrement count and issue the stack read
      OP_POP_DONE,        // capture the read data into the result register
      OP_PUSH,            // write the freed index on top and report
      OP_REFUSE,          // report a refused action, state unchanged
      OP_CLEAR,           // empty the stack and report
      OP_FILL_STEP,       // write one refill entry
      OP_FILL_LAST        // write the last refill entry and set the count
   } op_type;

   typedef enum logic [1:0] {
      ST_INIT_FILL,
      ST_IDLE,
      ST_POP,
      ST_FILL
   } state_type;

   typedef struct packed {
      action_type action;     // action of the item on the input
      logic       alloc_ok;   // stack holds at least one index
      logic       free_ok;    // room on the stack and index below capacity
      logic       cap_zero;   // effective capacity is zero
      logic       fill_last;  // refill pointer at the last entry
      logic       rsp_room;   // result register empty or being taken
   } status_type;

endpackage

// ----- design/fisa_ram.sv -----
// Generic single-port RAM with registered read data.
// Used for the free index stack. No dependencies.
module fisa_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/fisa_ctrl.sv -----
// Controller state machine for the free index stack allocator.
// Depends on fisa_pkg; drives commands to fisa_datapath from its status.
module fisa_ctrl
   import fisa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output op_type     op
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT_FILL: begin
            // The power-up refill writes the stack but sends no result.
            if (status.fill_last) begin
               op       = OP_FILL_LAST;
               state_in = ST_IDLE;
            end else begin
               op = OP_FILL_STEP;
            end
         end
         ST_IDLE: begin
            req_ready = status.rsp_room;
            if (req_valid && status.rsp_room) begin
               case (status.action)
                  ACT_ALLOC: begin
                     if (status.alloc_ok) begin
                        op       = OP_POP;
                        state_in = ST_POP;
                     end else begin
                        op = OP_REFUSE;
                     end
                  end
                  ACT_FREE: begin
                     op = status.free_ok ? OP_PUSH : OP_REFUSE;
                  end
                  ACT_REFILL: begin
                     // An empty pool refills to nothing, which is a clear.
                     if (status.cap_zero) begin
                        op = OP_CLEAR;
                     end else begin
                        state_in = ST_FILL;
                     end
                  end
                  ACT_CLEAR: begin
                     op = OP_CLEAR;
                  end
                  default: begin
                     op = OP_REFUSE;
                  end
               endcase
            end
         end
         ST_POP: begin
            op       = OP_POP_DONE;
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            if (status.fill_last) begin
               op       = OP_FILL_LAST;
               state_in = ST_IDLE;
            end else begin
               op = OP_FILL_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/fisa_datapath.sv -----
// Datapath of the free index stack allocator: capacity register, stack
// memory, count, refill pointer and result register.
// Depends on fisa_pkg and fisa_ram; commanded by fisa_ctrl.
module fisa_datapath
   import fisa_pkg::*;
#(
   parameter int STORE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   // command and status
   input  op_type            op,
   input  logic              fill_respond,
   output status_type        status,
   // input item fields
   input  logic [ACT_W-1:0]  action,
   input  logic [IDX_W-1:0]  freed_index,
   // result register
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              ok,
   output logic [IDX_W-1:0]  granted_index,
   output logic [CNT_W-1:0]  free_count,
   // capacity register access
   input  logic              cap_we,
   input  logic [CNT_W-1:0]  cap_wdata,
   output logic [CNT_W-1:0]  slot_capacity
);

   localparam int ADDR_W    = $clog2(STORE_DEPTH);
   localparam int CAP_LIMIT = (STORE_DEPTH > 127) ? 127 : STORE_DEPTH;

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  fill_idx_ff, fill_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              ok_ff, ok_in;
   logic [IDX_W-1:0]  granted_ff, granted_in;
   logic [CNT_W-1:0]  rcount_ff, rcount_in;

   logic [CNT_W-1:0]  eff_cap;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [IDX_W-1:0]  ram_wdata;
   logic [IDX_W-1:0]  ram_rdata;
   logic              fill_write;

   // The capacity saturates at the store depth.
   assign eff_cap = (int'(cap_ff) > CAP_LIMIT) ? CNT_W'(CAP_LIMIT) : cap_ff;

   assign status.action    = action_type'(action);
   assign status.alloc_ok  = (count_ff != '0) && (int'(count_ff) <= STORE_DEPTH);
   assign status.free_ok   = (count_ff < eff_cap) && ({1'b0, freed_index} < eff_cap);
   assign status.cap_zero  = (eff_cap == '0);
   assign status.fill_last = (fill_idx_ff == eff_cap - 7'd1);
   assign status.rsp_room  = !rsp_valid_ff || rsp_ready;

   assign fill_write = (op == OP_FILL_STEP) || (op == OP_FILL_LAST);

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = '0;
      ram_wdata = '0;
      case (op)
         OP_POP: begin
            ram_addr = ADDR_W'(count_ff - 7'd1);
         end
         OP_PUSH: begin
            ram_we    = 1'b1;
            ram_addr  = ADDR_W'(count_ff);
            ram_wdata = freed_index;
         end
         OP_FILL_STEP, OP_FILL_LAST: begin
            ram_we    = 1'b1;
            ram_addr  = ADDR_W'(fill_idx_ff);
            ram_wdata = IDX_W'(eff_cap - 7'd1 - fill_idx_ff);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   fisa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (STORE_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      cap_in       = cap_we ? cap_wdata : cap_ff;
      count_in     = count_ff;
      fill_idx_in  = fill_write ? fill_idx_ff + 7'd1 : fill_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ok_in        = ok_ff;
      granted_in   = granted_ff;
      rcount_in    = rcount_ff;
      case (op)
         OP_POP: begin
            count_in = count_ff - 7'd1;
         end
         OP_POP_DONE: begin
            rsp_valid_in = 1'b1;
            ok_in        = 1'b1;
            granted_in   = ram_rdata;
            rcount_in    = count_ff;
         end
         OP_PUSH: begin
            count_in     = count_ff + 7'd1;
            rsp_valid_in = 1'b1;
            ok_in        = 1'b1;
            granted_in   = '0;
            rcount_in    = count_ff + 7'd1;
         end
         OP_REFUSE: begin
            rsp_valid_in = 1'b1;
            ok_in        = 1'b0;
            granted_in   = '0;
            rcount_in    = count_ff;
         end
         OP_CLEAR: begin
            count_in     = '0;
            rsp_valid_in = 1'b1;
            ok_in        = 1'b1;
            granted_in   = '0;
            rcount_in    = '0;
         end
         OP_FILL_LAST: begin
            count_in    = eff_cap;
            fill_idx_in = '0;
            if (fill_respond) begin
               rsp_valid_in = 1'b1;
               ok_in        = 1'b1;
               granted_in   = '0;
               rcount_in    = eff_cap;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         fill_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         fill_idx_ff  <= fill_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ok_ff      <= ok_in;
      granted_ff <= granted_in;
      rcount_ff  <= rcount_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign ok            = ok_ff;
   assign granted_index = granted_ff;
   assign free_count    = rcount_ff;
   assign slot_capacity = cap_ff;

endmodule

// ----- design/free_index_stack_allocator_core.sv -----
// Top level of the free index stack allocator.
// Depends on fisa_pkg, fisa_ctrl, fisa_datapath and fisa_ram.
//
//   Channel   Ports          Direction  Item contents
//   -------   -----          ---------  -------------------------------------
//   request   req_t*         in         action, freed_index
//   response  rsp_t*         out        ok, granted_index, free_count
//   config    csr_p*         in/out     slot_capacity at byte address 0
//
// A free, a clear or a refused action is done in the idle state; an allocate
// also passes through ST_POP, because the stack memory has a registered read
// port. A refill accepts the item and then writes one stack entry per cycle
// up to the effective capacity before its result is ready.
// After reset the block runs the same refill pass (over the default capacity
// of 64, or the store depth if smaller) and accepts no item until it ends.
// Items are handled one at a time; a new item is taken as soon as the result
// register is empty or being taken, so a stalled response holds the request
// side only while the result waits.
module free_index_stack_allocator_core
   import fisa_pkg::*;
#(
   parameter int STORE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,    // [1:0] action, [7:2] freed_index
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,    // [0] ok, [6:1] granted_index,
                                           // [13:7] free_count, [15:14] zero
   // configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   status_type       status;
   op_type           op;
   logic             fill_respond;
   logic             cap_we;
   logic             cap_sel;
   logic             ok;
   logic [IDX_W-1:0] granted_index;
   logic [CNT_W-1:0] free_count;
   logic [CNT_W-1:0] slot_capacity;

   // The config port never waits. Only word index zero holds a register;
   // writes elsewhere are dropped and reads elsewhere return zero.
   assign csr_pready = 1'b1;
   assign cap_sel    = (csr_paddr[CSR_AW-1:2] == REG_SLOT_CAPACITY);
   assign cap_we     = csr_psel && csr_penable && csr_pwrite && cap_sel;
   assign csr_prdata = cap_sel ? {{(CSR_DW-CNT_W){1'b0}}, slot_capacity} : '0;

   fisa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .op        (op)
   );

   // Only a refill that came in as an item produces a result; the power-up
   // pass completes silently. The refill pass after reset is the only one
   // that starts without an accepted item, so a flag set by reset and
   // cleared at the end of that pass tells the two apart.
   logic init_ff, init_in;

   always_comb begin
      init_in = init_ff;
      if (op == OP_FILL_LAST) begin
         init_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 1'b1;
      end else begin
         init_ff <= init_in;
      end
   end

   assign fill_respond = !init_ff;

   fisa_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .fill_respond  (fill_respond),
      .status        (status),
      .action        (req_tdata[ACT_W-1:0]),
      .freed_index   (req_tdata[ACT_W+IDX_W-1:ACT_W]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .ok            (ok),
      .granted_index (granted_index),
      .free_count    (free_count),
      .cap_we        (cap_we),
      .cap_wdata     (csr_pwdata[CNT_W-1:0]),
      .slot_capacity (slot_capacity)
   );

   assign rsp_tdata = {{(RSP_W-1-IDX_W-CNT_W){1'b0}}, free_count, granted_index, ok};

endmodule
